/* sv/ppg_pkg.sv */
package ppg_pkg;

    // Register map of the configuration port
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_RADIUS       = 3'd2,
        REG_SPATIAL_STEP = 3'd3,
        REG_GREEN_OFFSET = 3'd4,
        REG_BLUE_OFFSET  = 3'd5
    } cfg_reg_t;

    // Reset values of the registers
    localparam int RST_CENTER_X     = 120;
    localparam int RST_CENTER_Y     = 120;
    localparam int RST_RADIUS       = 120;
    localparam int RST_SPATIAL_STEP = 33;
    localparam int RST_GREEN_OFFSET = 1369;
    localparam int RST_BLUE_OFFSET  = 2738;

    // Quarter-wave sine polynomial, Q16
    localparam logic [13:0] SIN_C3 = 14'd9279;
    localparam logic [16:0] SIN_C2 = 17'd84094;
    localparam logic [17:0] SIN_C1 = 18'd205887;

    // 65536 / (2*pi), rounded
    localparam logic signed [14:0] TURN_SCALE = 15'sd10430;

    // Channel bias and gain: 128 + 127*sin
    localparam int CHAN_BIAS = 128;
    localparam int CHAN_GAIN = 127;

endpackage

/* sv/ppg_sine.sv */
module ppg_sine
    import ppg_pkg::*;
#(
    parameter int PHASE_BITS     = 12,
    parameter int SINE_FRAC_BITS = 14
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [PHASE_BITS-1:0]            angle,
    output logic signed [SINE_FRAC_BITS+1:0] sine
);

    localparam int PB  = PHASE_BITS;
    localparam int F   = SINE_FRAC_BITS;
    localparam int ZSH = 18 - PB;
    localparam int SH  = 16 - F;
    localparam logic [PB-2:0] QUARTER = {1'b1, {(PB-2){1'b0}}};
    localparam logic [17:0]   HALF    = (18'd1 << SH) >> 1;

    // stage A: quadrant fold
    logic [1:0]    quad;
    logic [PB-2:0] wq;
    logic [PB-2:0] wm;
    logic [16:0]   za_next;
    logic [16:0]   za_reg;
    logic          nega_reg;

    // stage B: z^2
    logic [33:0]   zz;
    logic [16:0]   z2b_reg;
    logic [16:0]   zb_reg;
    logic          negb_reg;

    // stage C: t1
    logic [30:0]   t1p;
    logic [13:0]   t1c_reg;
    logic [16:0]   z2c_reg;
    logic [16:0]   zc_reg;
    logic          negc_reg;

    // stage D: t3
    logic [16:0]   m1;
    logic [33:0]   t3p;
    logic [16:0]   t3d_reg;
    logic [16:0]   zd_reg;
    logic          negd_reg;

    // stage E: final product, rounding, sign
    logic [17:0]   m2;
    logic [34:0]   sp;
    logic [17:0]   rnd;
    logic [F:0]    mag;
    logic signed [F+1:0] sine_next;
    logic signed [F+1:0] sine_reg;

    always_comb
    begin
        quad    = angle[PB-1:PB-2];
        wq      = {1'b0, angle[PB-3:0]};
        wm      = quad[0] ? (QUARTER - wq) : wq;
        za_next = 17'(wm) << ZSH;

        zz  = za_reg * za_reg;
        t1p = z2b_reg * SIN_C3;
        m1  = SIN_C2 - 17'(t1c_reg);
        t3p = z2c_reg * m1;
        m2  = SIN_C1 - 18'(t3d_reg);
        sp  = zd_reg * m2;
        rnd = 18'(sp[33:17]) + HALF;
        mag = rnd[SH +: F+1];
        sine_next = negd_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            za_reg   <= za_next;
            nega_reg <= quad[1];

            z2b_reg  <= zz[32:16];
            zb_reg   <= za_reg;
            negb_reg <= nega_reg;

            t1c_reg  <= t1p[29:16];
            z2c_reg  <= z2b_reg;
            zc_reg   <= zb_reg;
            negc_reg <= negb_reg;

            t3d_reg  <= t3p[32:16];
            zd_reg   <= zc_reg;
            negd_reg <= negc_reg;

            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

/* sv/plasma_pixel_generator_core.sv */
// Plasma pixel generator.
// Input channel: in_valid/in_stall with pixel_x, pixel_y, frame_phase. Output
// channel: out_valid/out_stall with pixel_color (RGB565, black outside the
// configured circle). One item in gives exactly one item out, in order.
// Configuration: cfg_write/cfg_index/cfg_data, one register per enabled edge;
// indexes past the register list are ignored. Write only while idle.
// Throughput: one item per clock while out_stall does not hold the pipeline.
// Depth: 18 register stages, the last being the pixel_color output register; the depth
// is set by two five-stage sine units in series, the square/step multipliers
// in front, and the turn conversion between them.
// The whole pipeline advances on one enable. While the output register holds
// an item and out_stall is high, every stage holds and in_stall is raised, so
// nothing is lost or repeated; empty stages fill as soon as the stall drops.
// Reset (rst_n low, async) empties every stage and loads the register defaults:
// center 120,120, radius 120, step 33, green offset 1369, blue offset 2738.
module plasma_pixel_generator_core
    import ppg_pkg::*;
#(
    parameter int PHASE_BITS     = 12,
    parameter int SINE_FRAC_BITS = 14,
    parameter int COORD_BITS     = 8,
    localparam int CFG_W = (PHASE_BITS > COORD_BITS) ? PHASE_BITS : COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic [PHASE_BITS-1:0] frame_phase,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           pixel_color
);

    localparam int PB  = PHASE_BITS;
    localparam int F   = SINE_FRAC_BITS;
    localparam int CW  = COORD_BITS;
    localparam int NST = 18;          // pipeline depth
    localparam int PHN = 10;          // phase carried from stage 1 to stage 10
    localparam int INN = 15;          // inside flag from stage 3 to stage 17
    localparam int SH2 = F + 16 - PB; // turn conversion shift
    localparam logic signed [F+18:0] HALF2 = {{(F+18){1'b0}}, 1'b1} << (SH2 - 1);
    localparam logic signed [F+8:0]  BIAS  = (F+9)'(CHAN_BIAS) << F;
    localparam logic signed [8:0]    GAIN  = 9'(CHAN_GAIN);

    // ---------------- configuration registers ----------------
    logic [CW-1:0] center_x_reg;
    logic [CW-1:0] center_y_reg;
    logic [CW-1:0] radius_reg;
    logic [PB-1:0] spatial_step_reg;
    logic [PB-1:0] green_offset_reg;
    logic [PB-1:0] blue_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= CW'(RST_CENTER_X);
            center_y_reg     <= CW'(RST_CENTER_Y);
            radius_reg       <= CW'(RST_RADIUS);
            spatial_step_reg <= PB'(RST_SPATIAL_STEP);
            green_offset_reg <= PB'(RST_GREEN_OFFSET);
            blue_offset_reg  <= PB'(RST_BLUE_OFFSET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CENTER_X:     center_x_reg     <= cfg_data[CW-1:0];
                REG_CENTER_Y:     center_y_reg     <= cfg_data[CW-1:0];
                REG_RADIUS:       radius_reg       <= cfg_data[CW-1:0];
                REG_SPATIAL_STEP: spatial_step_reg <= cfg_data[PB-1:0];
                REG_GREEN_OFFSET: green_offset_reg <= cfg_data[PB-1:0];
                REG_BLUE_OFFSET:  blue_offset_reg  <= cfg_data[PB-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en        = !(vld_reg[NST-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // side lines: frame phase and inside flag
    logic [PB-1:0] ph_pipe_reg  [PHN];
    logic          ins_pipe_reg [INN];

    // ---------------- stage 1: offsets ----------------
    logic signed [CW:0]   dx_next, dy_next;
    logic signed [CW+1:0] ds_next;
    logic signed [CW:0]   dx_reg, dy_reg;
    logic signed [CW+1:0] ds_reg;

    // ---------------- stage 2: squares and step products ----------------
    logic signed [2*CW+1:0]  sqx_full, sqy_full;
    logic signed [CW+PB+2:0] mx_full, my_full, ms_full;
    logic [2*CW-1:0]         sqx_reg, sqy_reg, rr_reg;
    logic [PB-1:0]           mx_reg, my_reg, ms_reg;

    // ---------------- stage 3: circle test, angles ----------------
    logic [2*CW:0] dsq;
    logic          inside_next;
    logic [PB-1:0] angx_reg, angy_reg, angs_reg;

    // ---------------- stages 4..8: field sines ----------------
    logic signed [F+1:0] sx, sy, ss;

    // ---------------- stages 9..12 ----------------
    logic signed [F+3:0]  sum_reg;
    logic signed [F+18:0] prod_reg;
    logic signed [F+18:0] rnd;
    logic [PB-1:0]        base_reg;
    logic [PB-1:0]        angr_reg, angg_reg, angb_reg;

    // ---------------- stages 13..18: channel sines, color ----------------
    logic signed [F+1:0] sr, sg, sb;
    logic signed [F+8:0] nr, ng, nb;
    logic [15:0]         color_next;
    logic [15:0]         color_reg;

    always_comb
    begin
        dx_next = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x_reg});
        dy_next = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y_reg});
        ds_next = dx_next + dy_next;

        sqx_full = dx_reg * dx_reg;
        sqy_full = dy_reg * dy_reg;
        // only the low PB bits of each product matter: angles wrap per turn
        mx_full  = dx_reg * $signed({1'b0, spatial_step_reg});
        my_full  = dy_reg * $signed({1'b0, spatial_step_reg});
        ms_full  = ds_reg * $signed({1'b0, spatial_step_reg});

        dsq         = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        inside_next = (dsq <= {1'b0, rr_reg});

        // round half up, then keep one turn
        rnd = prod_reg + HALF2;

        nr = BIAS + GAIN * sr;
        ng = BIAS + GAIN * sg;
        nb = BIAS + GAIN * sb;
        color_next = {nr[F+7:F+3], ng[F+7:F+2], nb[F+7:F+3]};
        if (!ins_pipe_reg[INN-1])
            color_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_pipe_reg[0] <= frame_phase;
            for (int i = 1; i < PHN; i++)
                ph_pipe_reg[i] <= ph_pipe_reg[i-1];

            ins_pipe_reg[0] <= inside_next;
            for (int i = 1; i < INN; i++)
                ins_pipe_reg[i] <= ins_pipe_reg[i-1];

            dx_reg <= dx_next;
            dy_reg <= dy_next;
            ds_reg <= ds_next;

            sqx_reg <= sqx_full[2*CW-1:0];
            sqy_reg <= sqy_full[2*CW-1:0];
            rr_reg  <= radius_reg * radius_reg;
            mx_reg  <= mx_full[PB-1:0];
            my_reg  <= my_full[PB-1:0];
            ms_reg  <= ms_full[PB-1:0];

            angx_reg <= mx_reg + ph_pipe_reg[1];
            angy_reg <= my_reg + ph_pipe_reg[1];
            angs_reg <= ms_reg + ph_pipe_reg[1];

            sum_reg  <= sx + sy + ss;
            prod_reg <= sum_reg * TURN_SCALE;
            base_reg <= rnd[SH2 +: PB] + ph_pipe_reg[PHN-1];

            angr_reg <= base_reg;
            angg_reg <= base_reg + green_offset_reg;
            angb_reg <= base_reg + blue_offset_reg;

            color_reg <= color_next;
        end
    end

    ppg_sine #(.PHASE_BITS(PB), .SINE_FRAC_BITS(F)) u_sin_x
    (
        .clk(clk), .en(en), .angle(angx_reg), .sine(sx)
    );

    ppg_sine #(.PHASE_BITS(PB), .SINE_FRAC_BITS(F)) u_sin_y
    (
        .clk(clk), .en(en), .angle(angy_reg), .sine(sy)
    );

    ppg_sine #(.PHASE_BITS(PB), .SINE_FRAC_BITS(F)) u_sin_s
    (
        .clk(clk), .en(en), .angle(angs_reg), .sine(ss)
    );

    ppg_sine #(.PHASE_BITS(PB), .SINE_FRAC_BITS(F)) u_sin_r
    (
        .clk(clk), .en(en), .angle(angr_reg), .sine(sr)
    );

    ppg_sine #(.PHASE_BITS(PB), .SINE_FRAC_BITS(F)) u_sin_g
    (
        .clk(clk), .en(en), .angle(angg_reg), .sine(sg)
    );

    ppg_sine #(.PHASE_BITS(PB), .SINE_FRAC_BITS(F)) u_sin_b
    (
        .clk(clk), .en(en), .angle(angb_reg), .sine(sb)
    );

    assign pixel_color = color_reg;

endmodule
